// ===== hdl/mfd_pkg.sv =====
package mfd_pkg;

    // Pipeline depth: input register, six scaling stages, output register.
    localparam int NUM_STAGES = 8;
    localparam int OUT_STAGE  = NUM_STAGES - 1;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 152;
    localparam int CFG_IDX_W  = 3;
    localparam int VALUE_W    = 32;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_MAX   = 3'd5;

    // Reset ranges, Q16.16.
    localparam logic signed [VALUE_W-1:0] RST_POSITION_MIN = -32'sd819200;
    localparam logic signed [VALUE_W-1:0] RST_POSITION_MAX =  32'sd819200;
    localparam logic signed [VALUE_W-1:0] RST_VELOCITY_MIN = -32'sd1966080;
    localparam logic signed [VALUE_W-1:0] RST_VELOCITY_MAX =  32'sd1966080;
    localparam logic signed [VALUE_W-1:0] RST_TORQUE_MIN   = -32'sd655360;
    localparam logic signed [VALUE_W-1:0] RST_TORQUE_MAX   =  32'sd655360;

    // Per-stage load enables and occupancy, shared by all lanes.
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
        logic [NUM_STAGES-1:0] vld;
    } pipe_ctrl_t;

    // Fields that ride alongside the scaling lanes unchanged.
    typedef struct packed {
        logic [7:0] rotor_temp;
        logic [7:0] stage_temp;
        logic [3:0] state_code;
        logic [3:0] motor_id;
    } frame_meta_t;

endpackage

// ===== hdl/motor_feedback_frame_decoder_top.sv =====
// Channel   Direction  Word                     Handshake
// s_        in         8 frame bytes, 64 bits   s_tvalid / s_tready
// m_        out        decoded frame, 152 bits  m_tvalid / m_tready
// cfg_      in         range register write     cfg_valid / cfg_ready
//
// Each frame passes through the input register plus seven pipeline stages of
// the three scaling lanes. One frame a cycle is sustained while m_tready stays high.
// Reset (aresetn low, synchronous) empties the pipeline, loads the reset
// ranges and clears the frame count. A stalled output holds; empty stages
// keep filling, so s_tready stays high until all 8 stages are occupied.
module motor_feedback_frame_decoder_top #(
    parameter int POSITION_BITS  = 16,
    parameter int VELTORQUE_BITS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // byte_0 [7:0], byte_1 [15:8], byte_2 [23:16], byte_3 [31:24],
    // byte_4 [39:32], byte_5 [47:40], byte_6 [55:48], byte_7 [63:56]
    input  logic [mfd_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // motor_id [3:0], state_code [7:4], position [39:8], velocity [71:40],
    // torque [103:72], stage_temp [111:104], rotor_temp [119:112],
    // frames_decoded [151:120]
    output logic [mfd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfd_pkg::VALUE_W-1:0]        cfg_data
);

    localparam int VW = mfd_pkg::VALUE_W;

    mfd_pkg::pipe_ctrl_t pipe;

    logic signed [VW-1:0] pos_min_reg;
    logic signed [VW-1:0] pos_max_reg;
    logic signed [VW-1:0] vel_min_reg;
    logic signed [VW-1:0] vel_max_reg;
    logic signed [VW-1:0] tor_min_reg;
    logic signed [VW-1:0] tor_max_reg;

    logic [mfd_pkg::IN_DATA_W-1:0] in_reg;
    mfd_pkg::frame_meta_t          meta_reg [1:mfd_pkg::OUT_STAGE];
    mfd_pkg::frame_meta_t          meta_next;
    logic [VW-1:0]                 count_reg;
    logic [VW-1:0]                 count_next;

    logic [15:0] pos_raw;
    logic [11:0] vel_raw;
    logic [11:0] tor_raw;
    logic [VW-1:0] position;
    logic [VW-1:0] velocity;
    logic [VW-1:0] torque;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_min_reg <= mfd_pkg::RST_POSITION_MIN;
            pos_max_reg <= mfd_pkg::RST_POSITION_MAX;
            vel_min_reg <= mfd_pkg::RST_VELOCITY_MIN;
            vel_max_reg <= mfd_pkg::RST_VELOCITY_MAX;
            tor_min_reg <= mfd_pkg::RST_TORQUE_MIN;
            tor_max_reg <= mfd_pkg::RST_TORQUE_MAX;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mfd_pkg::REG_POSITION_MIN: pos_min_reg <= cfg_data;
                mfd_pkg::REG_POSITION_MAX: pos_max_reg <= cfg_data;
                mfd_pkg::REG_VELOCITY_MIN: vel_min_reg <= cfg_data;
                mfd_pkg::REG_VELOCITY_MAX: vel_max_reg <= cfg_data;
                mfd_pkg::REG_TORQUE_MIN:   tor_min_reg <= cfg_data;
                mfd_pkg::REG_TORQUE_MAX:   tor_max_reg <= cfg_data;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    mfd_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .pipe      (pipe)
    );

    assign s_tready = pipe.ld[0];
    assign m_tvalid = pipe.vld[mfd_pkg::OUT_STAGE];

    // Unpack the held frame word.
    always_comb begin
        pos_raw              = {in_reg[15:8], in_reg[23:16]};
        vel_raw              = {in_reg[31:24], in_reg[39:36]};
        tor_raw              = {in_reg[35:32], in_reg[47:40]};
        meta_next.motor_id   = in_reg[3:0];
        meta_next.state_code = in_reg[7:4];
        meta_next.stage_temp = in_reg[55:48];
        meta_next.rotor_temp = in_reg[63:56];
        count_next           = count_reg + {{(VW-1){1'b0}}, 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (pipe.ld[0]) begin
            in_reg <= s_tdata;
        end
        if (pipe.ld[1]) begin
            meta_reg[1] <= meta_next;
        end
        for (int k = 2; k <= mfd_pkg::OUT_STAGE; k++) begin
            if (pipe.ld[k]) begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    // Count each word as it lands in the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (pipe.ld[mfd_pkg::OUT_STAGE] && pipe.vld[mfd_pkg::OUT_STAGE-1]) begin
            count_reg <= count_next;
        end
    end

    mfd_scale_lane #(.RAW_BITS(POSITION_BITS)) u_pos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pipe     (pipe),
        .raw_in   (pos_raw[POSITION_BITS-1:0]),
        .range_lo (pos_min_reg),
        .range_hi (pos_max_reg),
        .scaled   (position)
    );

    mfd_scale_lane #(.RAW_BITS(VELTORQUE_BITS)) u_vel (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pipe     (pipe),
        .raw_in   (vel_raw[VELTORQUE_BITS-1:0]),
        .range_lo (vel_min_reg),
        .range_hi (vel_max_reg),
        .scaled   (velocity)
    );

    mfd_scale_lane #(.RAW_BITS(VELTORQUE_BITS)) u_tor (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pipe     (pipe),
        .raw_in   (tor_raw[VELTORQUE_BITS-1:0]),
        .range_lo (tor_min_reg),
        .range_hi (tor_max_reg),
        .scaled   (torque)
    );

    assign m_tdata = {count_reg,
                      meta_reg[mfd_pkg::OUT_STAGE].rotor_temp,
                      meta_reg[mfd_pkg::OUT_STAGE].stage_temp,
                      torque,
                      velocity,
                      position,
                      meta_reg[mfd_pkg::OUT_STAGE].state_code,
                      meta_reg[mfd_pkg::OUT_STAGE].motor_id};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe.ld[mfd_pkg::OUT_STAGE] && pipe.vld[mfd_pkg::OUT_STAGE-1])
        |=> (count_reg == $past(count_reg) + 32'd1))
        else $error("frame count did not advance");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(count_reg))
        else $error("frame count changed under stall");

    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe.vld[0] |-> s_tready)
        else $error("input stalled with empty input stage");

endmodule

// ===== hdl/mfd_pipe_ctrl.sv =====
module mfd_pipe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                out_ready,
    output mfd_pkg::pipe_ctrl_t pipe
);

    logic [mfd_pkg::NUM_STAGES-1:0] vld_reg;
    logic [mfd_pkg::NUM_STAGES-1:0] vld_next;
    logic [mfd_pkg::NUM_STAGES-1:0] ld;

    // A stage loads when it is empty or its word moves on; bubbles collapse.
    always_comb begin
        ld[mfd_pkg::OUT_STAGE] = !vld_reg[mfd_pkg::OUT_STAGE] || out_ready;
        for (int k = mfd_pkg::OUT_STAGE - 1; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
        vld_next[0] = ld[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < mfd_pkg::NUM_STAGES; k++) begin
            vld_next[k] = ld[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign pipe.ld  = ld;
    assign pipe.vld = vld_reg;

endmodule

// ===== hdl/mfd_scale_lane.sv =====
module mfd_scale_lane #(
    parameter int RAW_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mfd_pkg::pipe_ctrl_t        pipe,
    input  logic [RAW_BITS-1:0]        raw_in,
    input  logic signed [mfd_pkg::VALUE_W-1:0] range_lo,
    input  logic signed [mfd_pkg::VALUE_W-1:0] range_hi,
    output logic [mfd_pkg::VALUE_W-1:0] scaled
);

    localparam int VW = mfd_pkg::VALUE_W;
    localparam int XW = RAW_BITS + VW;
    localparam int TW = XW + 1;
    localparam logic [TW-1:0] FULL = TW'((65'd1 << RAW_BITS) - 65'd1);

    logic [RAW_BITS-1:0] raw_reg;
    logic [VW-1:0]       mag_reg;
    logic                neg_reg [1:6];
    logic [VW-1:0]       lo_reg  [1:6];
    logic [XW-1:0]       x_reg   [2:6];
    logic [TW-1:0]       t_reg   [3:5];
    logic [VW-1:0]       q_reg;
    logic [VW-1:0]       scaled_reg;

    logic [VW:0]   span_next;
    logic [VW:0]   span_abs;
    logic [XW-1:0] x_next;
    logic [TW-1:0] t3_next;
    logic [TW-1:0] t4_next;
    logic [TW-1:0] t5_next;
    logic [VW-1:0] q0;
    logic [VW:0]   q0_inc;
    logic [TW-1:0] q0_inc_full;
    logic [VW-1:0] q_next;
    logic [VW-1:0] scaled_next;

    // Magnitude of raw * span is divided by 2^n - 1 through the series
    // 2^-n (1 + 2^-n)(1 + 2^-2n)(1 + 2^-4n); the estimate is at most one low.
    always_comb begin
        span_next   = {range_hi[VW-1], range_hi} - {range_lo[VW-1], range_lo};
        span_abs    = span_next[VW] ? (~span_next + {{VW{1'b0}}, 1'b1}) : span_next;
        x_next      = XW'(raw_reg) * XW'(mag_reg);
        t3_next     = {1'b0, x_reg[2]} + ({1'b0, x_reg[2]} >> RAW_BITS);
        t4_next     = t_reg[3] + (t_reg[3] >> (2 * RAW_BITS));
        t5_next     = t_reg[4] + (t_reg[4] >> (4 * RAW_BITS));
        q0          = t_reg[5][RAW_BITS +: VW];
        q0_inc      = {1'b0, q0} + {{VW{1'b0}}, 1'b1};
        q0_inc_full = {q0_inc, {RAW_BITS{1'b0}}} - TW'(q0_inc);
        q_next      = ({1'b0, x_reg[5]} >= q0_inc_full) ? q0_inc[VW-1:0] : q0;
        scaled_next = neg_reg[6] ? (lo_reg[6] - q_reg) : (lo_reg[6] + q_reg);
    end

    always_ff @(posedge aclk) begin
        if (pipe.ld[1]) begin
            raw_reg    <= raw_in;
            mag_reg    <= span_abs[VW-1:0];
            neg_reg[1] <= span_next[VW];
            lo_reg[1]  <= range_lo;
        end
        for (int k = 2; k <= 6; k++) begin
            if (pipe.ld[k]) begin
                neg_reg[k] <= neg_reg[k-1];
                lo_reg[k]  <= lo_reg[k-1];
            end
        end
        if (pipe.ld[2]) begin
            x_reg[2] <= x_next;
        end
        for (int k = 3; k <= 6; k++) begin
            if (pipe.ld[k]) begin
                x_reg[k] <= x_reg[k-1];
            end
        end
        if (pipe.ld[3]) begin
            t_reg[3] <= t3_next;
        end
        if (pipe.ld[4]) begin
            t_reg[4] <= t4_next;
        end
        if (pipe.ld[5]) begin
            t_reg[5] <= t5_next;
        end
        if (pipe.ld[6]) begin
            q_reg <= q_next;
        end
        if (pipe.ld[7]) begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

    // Quotient check: q * full <= x < (q + 1) * full.
    logic [TW-1:0] chk_qf;
    logic [TW-1:0] chk_rem;
    always_comb begin
        chk_qf  = {1'b0, q_reg, {RAW_BITS{1'b0}}} - TW'(q_reg);
        chk_rem = {1'b0, x_reg[6]} - chk_qf;
    end

    a_quot_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe.vld[6] |-> ({1'b0, x_reg[6]} >= chk_qf))
        else $error("quotient too large");

    a_quot_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe.vld[6] |-> (chk_rem < FULL))
        else $error("quotient remainder out of range");

endmodule
